/* rtl/core/sbps_pkg.sv */
`default_nettype none
package sbps_pkg;
   localparam int MaxDim = 1024;
   localparam int IdxW = $clog2(MaxDim);
   localparam int FracBits = 16;
   // dividend is |subgrad| shifted up by the fraction bits
   localparam int DivW = 32 + FracBits;
   // trial point and bound distance, point plus a full quotient with sign
   localparam int TrialW = DivW + 2;
   localparam logic [62:0] NormCap = {63{1'b1}};

   localparam logic CmdInit = 1'b0;
   localparam logic CmdUpdate = 1'b1;

   typedef struct packed {
      logic cmd;
      logic [9:0] elem_index;
      logic signed [31:0] subgrad;
      logic signed [31:0] point;
      logic signed [31:0] lower_bound;
      logic signed [31:0] upper_bound;
      logic [31:0] scale;
      logic is_fixed;
      logic is_bounded;
      logic last_elem;
   } req_type;

   typedef struct packed {
      logic [9:0] out_index;
      logic signed [31:0] new_point;
      logic signed [31:0] multiplier;
      logic signed [31:0] multiplier_delta;
      logic changed;
      logic [62:0] step_norm;
      logic last_out;
   } rsp_type;

   // saturate a wide signed value to 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
      logic signed [67:0] hi;
      logic signed [67:0] lo;
      hi = 68'sd2147483647;
      lo = -68'sd2147483648;
      if (v > hi) return 32'sh7fffffff;
      if (v < lo) return 32'sh80000000;
      return v[31:0];
   endfunction
endpackage
`default_nettype wire

/* rtl/core/sbps_ram.sv */
`default_nettype none
module sbps_ram #(
   parameter int Width = 32,
   parameter int Depth = 1024
) (
   input wire logic clock,
   input wire logic wr_en,
   input wire logic [$clog2(Depth)-1:0] wr_addr,
   input wire logic [Width-1:0] wr_data,
   input wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0] rd_data
);
   logic [Width-1:0] mem [Depth];

   // one write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

/* rtl/core/sbps_div.sv */
`default_nettype none
module sbps_div (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic [sbps_pkg::DivW-1:0] dividend,
   input wire logic [31:0] divisor,
   output logic done,
   output logic [sbps_pkg::DivW-1:0] quotient
);
   import sbps_pkg::*;

   logic [DivW-1:0] q_ff, q_in;
   logic [32:0] r_ff, r_in;
   logic [5:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic [31:0] dv_ff, dv_in;
   logic [32:0] trial;

   // restoring division, one quotient bit per cycle
   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      dv_in = dv_ff;
      done = 1'b0;
      trial = {r_ff[31:0], q_ff[DivW-1]};
      if (start) begin
         q_in = dividend;
         r_in = '0;
         cnt_in = 6'(DivW);
         busy_in = 1'b1;
         dv_in = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dv_ff}) begin
            r_in = trial - {1'b0, dv_ff};
            q_in = {q_ff[DivW-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[DivW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done = 1'b1;
         end
      end
   end
   assign quotient = q_in;

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
      dv_ff <= dv_in;
      cnt_ff <= cnt_in;
      if (reset) busy_ff <= 1'b0;
      else busy_ff <= busy_in;
   end
endmodule
`default_nettype wire

/* rtl/core/scaled_box_projected_step.sv */
// channel   | valid     | stall     | payload
// request   | req_valid | req_stall | req_data  (sbps_pkg::req_type)
// response  | rsp_valid | rsp_stall | rsp_data  (sbps_pkg::rsp_type)
// one transaction at a time: the next request is accepted only after the response
// is registered; the divider loads and then produces 48 quotient bits; a fixed
// coordinate skips the divider; the response is registered in the output step,
// a memory clear of all 1024 entries follows reset before the first transaction,
// four product steps on two 32x32 multipliers build the multiplier and norm term,
// a finished response waits in its register while rsp_stall is high.
`default_nettype none
module scaled_box_projected_step (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_stall,
   input wire sbps_pkg::req_type req_data,
   output logic rsp_valid,
   input wire logic rsp_stall,
   output sbps_pkg::rsp_type rsp_data
);
   import sbps_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_DIV, ST_PROJ, ST_MA, ST_MB, ST_SQ, ST_NA, ST_NB, ST_OUT
   } state_type;

   state_type st_ff;
   req_type r_ff;
   logic [IdxW-1:0] clr_ff;
   logic [31:0] s_ff;
   logic signed [TrialW-1:0] t_ff;       // trial point, wide
   logic signed [31:0] np_ff;
   logic signed [TrialW-1:0] diff_ff;    // bound minus trial
   logic div_run_ff;                     // divider started for this transaction
   logic [63:0] acc_ff;            // unsigned magnitude products
   logic [63:0] p_ff;
   logic signed [31:0] newm_ff;
   logic [63:0] norm_ff;
   rsp_type rsp_ff;
   logic rsp_valid_ff;

   logic div_start, div_done;
   logic [DivW-1:0] div_q;
   logic [DivW-1:0] div_a;
   logic [31:0] old_m;
   logic wr_en;
   logic [IdxW-1:0] wr_addr;
   logic [31:0] wr_data;

   assign div_a = {(r_ff.subgrad[31] ? -r_ff.subgrad : r_ff.subgrad), {FracBits{1'b0}}};
   assign div_start = (st_ff == ST_DIV) && !div_run_ff && !r_ff.is_fixed;

   sbps_div u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(div_a), .divisor(s_ff), .done(div_done), .quotient(div_q)
   );

   sbps_ram #(.Width(32), .Depth(MaxDim)) u_mem (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(r_ff.elem_index[IdxW-1:0]), .rd_data(old_m)
   );

   // magnitudes for the shifted products
   logic [TrialW-1:0] dmag;
   logic [32:0] stepmag;
   logic signed [33:0] step_w;
   logic [63:0] prod_lo, prod_hi;
   logic [95:0] mfull;
   logic [127:0] nfull;
   logic signed [67:0] mval;
   logic [63:0] nterm;
   logic [64:0] nsum;
   assign dmag = diff_ff[TrialW-1] ? -diff_ff : diff_ff;
   assign step_w = 34'(np_ff) - 34'(r_ff.point);
   assign stepmag = step_w[33] ? 33'(-step_w) : 33'(step_w);
   assign prod_lo = {32'd0, acc_ff[31:0]} * {32'd0, s_ff};
   assign prod_hi = {32'd0, acc_ff[63:32]} * {32'd0, s_ff};
   assign mfull = {p_ff, 32'd0} + {32'd0, prod_lo};
   assign mval = mfull[95:31+FracBits] != 0 ? 68'sh80000000
      : 68'(mfull[30+FracBits:FracBits]);
   assign nfull = {32'd0, p_ff, 32'd0} + {64'd0, prod_lo};
   assign nterm = nfull[127:63+FracBits] != 0 ? {1'b0, NormCap}
      : 64'(nfull[62+FracBits:FracBits]);
   assign nsum = {1'b0, norm_ff} + {1'b0, nterm};
   assign wr_en = st_ff == ST_CLEAR || st_ff == ST_OUT && !rsp_valid_ff;
   assign wr_addr = st_ff == ST_CLEAR ? clr_ff : r_ff.elem_index[IdxW-1:0];
   assign wr_data = st_ff == ST_CLEAR ? 32'd0 : newm_ff;
   assign req_stall = st_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   logic signed [TrialW-1:0] trial_w;
   assign trial_w = r_ff.subgrad[31] ? TrialW'(r_ff.point) + TrialW'(div_q)
                                     : TrialW'(r_ff.point) - TrialW'(div_q);

   // sequencer with registered datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_CLEAR;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
         norm_ff <= '0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         case (st_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == IdxW'(MaxDim - 1)) st_ff <= ST_IDLE;
            end
            ST_IDLE: if (req_valid) begin
               r_ff <= req_data;
               s_ff <= req_data.scale == 0 ? 32'd1 : req_data.scale;
               div_run_ff <= 1'b0;
               st_ff <= ST_DIV;
            end
            ST_DIV: begin
               if (r_ff.is_fixed) begin
                  t_ff <= TrialW'(r_ff.point);
                  st_ff <= ST_PROJ;
               end else if (div_done) begin
                  t_ff <= trial_w;
                  st_ff <= ST_PROJ;
               end
               div_run_ff <= 1'b1;
            end
            ST_PROJ: begin
               if (r_ff.is_bounded && t_ff < TrialW'(r_ff.lower_bound)) begin
                  np_ff <= r_ff.lower_bound;
                  diff_ff <= TrialW'(r_ff.lower_bound) - t_ff;
               end else if (r_ff.is_bounded && t_ff > TrialW'(r_ff.upper_bound)) begin
                  np_ff <= r_ff.upper_bound;
                  diff_ff <= TrialW'(r_ff.upper_bound) - t_ff;
               end else begin
                  np_ff <= r_ff.is_bounded ? t_ff[31:0] : sat32(68'(t_ff));
                  diff_ff <= '0;
               end
               st_ff <= ST_MA;
            end
            ST_MA: begin
               acc_ff <= 64'(dmag);
               st_ff <= ST_MB;
            end
            ST_MB: begin
               p_ff <= prod_hi;
               st_ff <= ST_SQ;
            end
            ST_SQ: begin
               if (!r_ff.is_bounded)
                  newm_ff <= r_ff.cmd == CmdInit ? 32'sd0 : old_m;
               else if (r_ff.cmd == CmdInit && r_ff.is_fixed) newm_ff <= 32'sd0;
               else if (diff_ff[TrialW-1]) newm_ff <= sat32(-mval);
               else newm_ff <= sat32(mval);
               acc_ff <= 64'(stepmag) * 64'(stepmag);
               st_ff <= ST_NA;
            end
            ST_NA: begin
               p_ff <= prod_hi;
               st_ff <= ST_NB;
            end
            ST_NB: begin
               norm_ff <= nsum > 65'(NormCap) ? {1'b0, NormCap} : nsum[63:0];
               st_ff <= ST_OUT;
            end
            ST_OUT: if (!rsp_valid_ff) begin
               rsp_ff.out_index <= r_ff.elem_index;
               rsp_ff.new_point <= np_ff;
               rsp_ff.multiplier <= newm_ff;
               rsp_ff.multiplier_delta <= sat32(68'(newm_ff) - 68'($signed(old_m)));
               rsp_ff.changed <= r_ff.cmd == CmdUpdate && newm_ff != old_m;
               rsp_ff.step_norm <= r_ff.last_elem ? norm_ff[62:0] : 63'd0;
               rsp_ff.last_out <= r_ff.last_elem;
               if (r_ff.last_elem) norm_ff <= '0;
               rsp_valid_ff <= 1'b1;
               st_ff <= ST_IDLE;
            end
            default: st_ff <= ST_IDLE;
         endcase
      end
   end

   // response only leaves the sequencer at the output step
   a_rsp_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(st_ff) == ST_OUT) else $error("rsp rise");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      st_ff != ST_IDLE |-> req_stall) else $error("stall");
   a_norm_cap: assert property (@(posedge clock) disable iff (reset)
      !norm_ff[63]) else $error("norm");
   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(rsp_ff)) else $error("hold");
endmodule
`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
   import sbps_pkg::req_type;
   import sbps_pkg::rsp_type;
   import sbps_pkg::CmdInit;
   import sbps_pkg::CmdUpdate;

   localparam logic [63:0] NormLimit = 64'h7fffffffffffffff;
   localparam logic [63:0] MultLimit = 64'h80000000;
   localparam int unsigned ScaleOne = 32'h10000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;

   int idle_pct = 0;
   int stall_pct = 0;
   int error_count = 0;

   // multiplier store and norm sum as the block should hold them
   int mult_shadow [1024];
   logic [63:0] norm_sum = '0;
   rsp_type pending_results [$];

   scaled_box_projected_step dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   // min((a * s) >> 16, cap) without overflow
   function automatic logic [63:0] scaled_product(logic [63:0] a, logic [63:0] s,
                                                  logic [63:0] cap);
      logic [127:0] p;
      p = ({64'd0, a} * {64'd0, s}) >> sbps_pkg::FracBits;
      return (p > {64'd0, cap}) ? cap : p[63:0];
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // signed multiplier from the distance to the violated bound
   function automatic int bound_multiplier(longint d, logic [63:0] s);
      logic [63:0] mag;
      longint v;
      mag = (d < 0) ? -d : d;
      mag = scaled_product(mag, s, MultLimit);
      v = (d < 0) ? -longint'(mag) : longint'(mag);
      return int'(clamp32(v));
   endfunction

   function automatic rsp_type project_elem(req_type r);
      rsp_type o;
      longint g, y, lb, ub, t, np, stp;
      logic [63:0] s, q, mg, sq, term;
      int old_m, new_m, m;
      g = r.subgrad;
      y = r.point;
      lb = r.lower_bound;
      ub = r.upper_bound;
      s = (r.scale == 0) ? 64'd1 : {32'd0, r.scale};
      old_m = mult_shadow[r.elem_index];
      new_m = old_m;
      if (r.is_fixed) begin
         t = y;
      end else begin
         mg = (g < 0) ? -g : g;
         q = (mg << sbps_pkg::FracBits) / s;
         t = (g < 0) ? y + longint'(q) : y - longint'(q);
      end
      if (r.is_bounded) begin
         m = 0;
         if (t < lb) begin
            m = bound_multiplier(lb - t, s);
            np = lb;
         end else if (t > ub) begin
            m = bound_multiplier(ub - t, s);
            np = ub;
         end else begin
            np = t;
         end
         new_m = (r.cmd == CmdInit && r.is_fixed) ? 0 : m;
      end else begin
         np = clamp32(t);
         if (r.cmd == CmdInit) new_m = 0;
      end
      mult_shadow[r.elem_index] = new_m;
      // squared step fits in 64 bits before scaling
      stp = np - y;
      mg = (stp < 0) ? -stp : stp;
      sq = mg * mg;
      term = scaled_product(sq, s, NormLimit);
      norm_sum = (norm_sum + term > NormLimit) ? NormLimit : norm_sum + term;
      o.out_index = r.elem_index;
      o.new_point = np[31:0];
      o.multiplier = new_m;
      o.multiplier_delta = 32'(clamp32(longint'(new_m) - longint'(old_m)));
      o.changed = (r.cmd == CmdUpdate && new_m != old_m);
      o.step_norm = r.last_elem ? norm_sum[62:0] : '0;
      o.last_out = r.last_elem;
      if (r.last_elem) norm_sum = '0;
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      error_count++;
   endtask

   // one request transaction, valid left high after acceptance
   task automatic send_elem(req_type r);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_results.push_back(project_elem(r));
   endtask

   function automatic req_type make_elem(logic cmd, logic [9:0] idx, int g, int y,
                                         int lb, int ub, int unsigned s,
                                         logic fx, logic bd, logic lst);
      req_type r;
      r.cmd = cmd;
      r.elem_index = idx;
      r.subgrad = g;
      r.point = y;
      r.lower_bound = lb;
      r.upper_bound = ub;
      r.scale = s;
      r.is_fixed = fx;
      r.is_bounded = bd;
      r.last_elem = lst;
      return r;
   endfunction

   // response stall pattern
   always @(posedge clock) rsp_stall <= ($urandom_range(99) < stall_pct);

   // check each response transaction against the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected response index", 64'(rsp_data.out_index), 64'd0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.out_index !== want.out_index)
               report_mismatch("out_index", 64'(rsp_data.out_index),
                               64'(want.out_index));
            if (rsp_data.new_point !== want.new_point)
               report_mismatch("new_point", 64'(rsp_data.new_point),
                               64'(want.new_point));
            if (rsp_data.multiplier !== want.multiplier)
               report_mismatch("multiplier", 64'(rsp_data.multiplier),
                               64'(want.multiplier));
            if (rsp_data.multiplier_delta !== want.multiplier_delta)
               report_mismatch("multiplier_delta", 64'(rsp_data.multiplier_delta),
                               64'(want.multiplier_delta));
            if (rsp_data.changed !== want.changed)
               report_mismatch("changed", 64'(rsp_data.changed), 64'(want.changed));
            if (rsp_data.step_norm !== want.step_norm)
               report_mismatch("step_norm", 64'(rsp_data.step_norm),
                               64'(want.step_norm));
            if (rsp_data.last_out !== want.last_out)
               report_mismatch("last_out", 64'(rsp_data.last_out), 64'(want.last_out));
         end
      end
   end

   // field extremes, both commands
   task automatic test_extremes();
      send_elem(make_elem(CmdInit, 10'd0, 0, 0, 0, 0, 0, 1'b0, 1'b0, 1'b0));
      send_elem(make_elem(CmdUpdate, 10'd1023, 32'sh7fffffff, 32'sh80000000,
                          32'sh80000000, 32'sh7fffffff, 1, 1'b0, 1'b1, 1'b0));
      send_elem(make_elem(CmdUpdate, 10'd1023, 32'sh80000000, 32'sh7fffffff,
                          32'sh80000000, 32'sh7fffffff, 32'hffffffff, 1'b0, 1'b1, 1'b0));
      send_elem(make_elem(CmdInit, 10'd512, 32'sh80000000, 32'sh7fffffff,
                          0, 0, 1, 1'b0, 1'b0, 1'b1));
      send_elem(make_elem(CmdUpdate, 10'd3, 32'sh7fffffff, 32'sh80000000,
                          0, 0, 1, 1'b0, 1'b0, 1'b0));
      send_elem(make_elem(CmdUpdate, 10'd4, 32'sh80000000, 32'sh7fffffff,
                          0, 0, 2, 1'b0, 1'b0, 1'b1));
   endtask

   // zero scale, crossed bounds, fixed and unbounded coordinates
   task automatic test_special_cases();
      send_elem(make_elem(CmdInit, 10'd7, 32'sh10000, 0, -32'sh20000, 32'sh20000,
                          0, 1'b0, 1'b1, 1'b0));
      send_elem(make_elem(CmdUpdate, 10'd7, 32'sh10000, 0, -32'sh20000, 32'sh20000,
                          0, 1'b0, 1'b1, 1'b0));
      // lower above upper: below lower, above upper, in between
      send_elem(make_elem(CmdUpdate, 10'd8, 0, -32'sh50000, 32'sh30000, 32'sh10000,
                          ScaleOne, 1'b0, 1'b1, 1'b0));
      send_elem(make_elem(CmdUpdate, 10'd9, 0, 32'sh50000, 32'sh30000, 32'sh10000,
                          ScaleOne, 1'b0, 1'b1, 1'b0));
      send_elem(make_elem(CmdUpdate, 10'd10, 0, 32'sh20000, 32'sh30000, 32'sh10000,
                          ScaleOne, 1'b0, 1'b1, 1'b0));
      // fixed coordinate outside the box: update, init, then update
      send_elem(make_elem(CmdUpdate, 10'd11, 32'sh40000, 32'sh90000, 0, 32'sh10000,
                          32'sh8000, 1'b1, 1'b1, 1'b0));
      send_elem(make_elem(CmdInit, 10'd11, 32'sh40000, 32'sh90000, 0, 32'sh10000,
                          32'sh8000, 1'b1, 1'b1, 1'b0));
      send_elem(make_elem(CmdUpdate, 10'd11, 32'sh40000, -32'sh90000, 0, 32'sh10000,
                          32'sh8000, 1'b1, 1'b1, 1'b0));
      // unbounded update keeps the multiplier, unbounded init clears it
      send_elem(make_elem(CmdUpdate, 10'd11, 32'sh30000, 32'sh1000, 0, 0,
                          ScaleOne, 1'b0, 1'b0, 1'b0));
      send_elem(make_elem(CmdInit, 10'd11, 32'sh30000, 32'sh1000, 0, 0,
                          ScaleOne, 1'b1, 1'b0, 1'b0));
      send_elem(make_elem(CmdUpdate, 10'd12, 32'sh30000, 32'sh1000, 0, 32'sh20000,
                          ScaleOne, 1'b0, 1'b1, 1'b0));
      send_elem(make_elem(CmdUpdate, 10'd12, 32'sh30000, 32'sh1000, 0, 32'sh20000,
                          ScaleOne, 1'b0, 1'b1, 1'b1));
   endtask

   function automatic req_type random_elem(bit noisy, bit lst);
      req_type r;
      int lb;
      logic [223:0] raw;
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      r = raw[$bits(req_type)-1:0];
      r.last_elem = lst;
      if (!noisy) begin
         lb = $signed($urandom) >>> $urandom_range(8, 14);
         r.lower_bound = lb;
         r.upper_bound = lb + ($urandom >> $urandom_range(9, 16));
         r.point = lb + ($signed($urandom) >>> $urandom_range(9, 16));
         r.subgrad = $signed($urandom) >>> $urandom_range(6, 16);
         r.scale = $urandom_range(32'h100000, 32'h1000);
         r.is_fixed = ($urandom_range(9) == 0);
         r.is_bounded = ($urandom_range(9) != 0);
      end
      return r;
   endfunction

   // vectors of random length, one phase of the idle and stall patterns
   task automatic test_random_vectors(int count, int idle, int stall);
      int len;
      idle_pct = idle;
      stall_pct = stall;
      while (count > 0) begin
         len = $urandom_range(12, 1);
         for (int k = 0; k < len; k++)
            send_elem(random_elem($urandom_range(4) == 0, k == len - 1));
         count -= len;
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_extremes();
      test_special_cases();
      test_random_vectors(300, 0, 0);
      test_random_vectors(300, 85, 0);
      test_random_vectors(300, 0, 85);
      test_random_vectors(300, 33, 33);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #30_000_000;
      $display("status: fail");
      $finish;
   end
endmodule
`default_nettype wire
